// ===== rtl/i2cts_pkg.sv =====
package i2cts_pkg;

	// Longest transfer length; a longer start request is clipped to it
	localparam int unsigned MAX_LENGTH_DEF = 255;

	// Status flag bit positions
	localparam int unsigned FL_BUSERR   = 0;
	localparam int unsigned FL_BUSY     = 1;
	localparam int unsigned FL_STOP     = 2;
	localparam int unsigned FL_STRETCH  = 3;
	localparam int unsigned FL_READ     = 4;
	localparam int unsigned FL_ACK      = 5;
	localparam int unsigned FL_TXREQ    = 6;
	localparam int unsigned FL_RXREQ    = 7;
	localparam int unsigned FL_LINEFREE = 8;
	localparam int unsigned FL_ADDRDATA = 9;

	typedef enum logic [2:0] {
		OP_START_W = 3'd0,
		OP_START_R = 3'd1,
		OP_STATUS  = 3'd2,
		OP_IDLE    = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		CMD_NONE      = 4'd0,
		CMD_START_W   = 4'd1,
		CMD_START_R   = 4'd2,
		CMD_SEND      = 4'd3,
		CMD_LAST      = 4'd4,
		CMD_ACK       = 4'd5,
		CMD_NACK_STOP = 4'd6,
		CMD_CLEAR     = 4'd7,
		CMD_REINIT    = 4'd8
	} cmd_t;

	// Transfer phase, one-hot
	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_WRITE = 6'b000010,
		PH_READ  = 6'b000100,
		PH_WDONE = 6'b001000,
		PH_RDONE = 6'b010000,
		PH_ERROR = 6'b100000
	} phase_t;

	// Driver state codes as reported on the result
	localparam logic [2:0] DS_IDLE  = 3'd0;
	localparam logic [2:0] DS_WRITE = 3'd1;
	localparam logic [2:0] DS_READ  = 3'd2;
	localparam logic [2:0] DS_WDONE = 3'd3;
	localparam logic [2:0] DS_RDONE = 3'd4;
	localparam logic [2:0] DS_ERROR = 3'd5;

	typedef struct packed {
		logic [2:0] operation;
		logic [6:0] slave_address;
		logic [7:0] transfer_length;
		logic [9:0] status_flags;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0] command;
		logic [7:0] data_out;
		logic       rx_store;
		logic [2:0] driver_state;
		logic       error_code;
		logic [7:0] remaining;
		logic       last;
	} out_item_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] bytes_left;
		logic [6:0] target_address;
		logic       fault_code;
		logic       overrun;
	} seq_state_t;

	// Results of one step: first and second transfer, and whether the second exists
	typedef struct packed {
		out_item_t r0;
		out_item_t r1;
		logic      two;
	} step_res_t;

	function automatic logic [2:0] phase_code(phase_t ph);
		logic [2:0] c;
		unique case (ph)
			PH_IDLE:  c = DS_IDLE;
			PH_WRITE: c = DS_WRITE;
			PH_READ:  c = DS_READ;
			PH_WDONE: c = DS_WDONE;
			PH_RDONE: c = DS_RDONE;
			PH_ERROR: c = DS_ERROR;
			default:  c = DS_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/i2cts_step.sv =====
module i2cts_step
	import i2cts_pkg::*;
#(
	parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  in_item_t   item,
	input  seq_state_t cur,
	output seq_state_t nxt,
	output step_res_t  res
);

	logic [9:0] fl;
	logic       base;
	logic       start_ok;
	logic [7:0] len_sat;
	cmd_t       cmd0;
	cmd_t       cmd1;
	logic [7:0] dat0;
	logic [7:0] dat1;
	logic       rxs0;
	logic       two;

	assign fl = item.status_flags;
	assign base = !fl[FL_BUSERR] && fl[FL_BUSY] && !fl[FL_STOP] && fl[FL_STRETCH];
	assign start_ok = !fl[FL_BUSY] && fl[FL_TXREQ] && fl[FL_LINEFREE];
	assign len_sat = (32'(item.transfer_length) > MAX_LENGTH) ?
		8'(MAX_LENGTH) : item.transfer_length;

	// Next state and commands for one item
	always_comb begin
		nxt  = cur;
		cmd0 = CMD_NONE;
		cmd1 = CMD_NONE;
		dat0 = '0;
		dat1 = '0;
		rxs0 = 1'b0;
		two  = 1'b0;
		unique case (op_t'(item.operation))
			OP_START_W, OP_START_R: begin
				nxt.target_address = item.slave_address;
				nxt.bytes_left     = len_sat;
				nxt.overrun        = 1'b0;
				if (start_ok) begin
					if (op_t'(item.operation) == OP_START_R) begin
						nxt.phase = PH_READ;
						cmd0      = CMD_START_R;
					end else begin
						nxt.phase = PH_WRITE;
						cmd0      = CMD_START_W;
					end
					dat0 = {1'b0, item.slave_address};
				end else begin
					nxt.phase      = PH_ERROR;
					nxt.fault_code = 1'b1;
				end
			end
			OP_IDLE: begin
				nxt.phase = PH_IDLE;
			end
			OP_CLEAR: begin
				nxt = '{phase: PH_IDLE, default: '0};
			end
			OP_STATUS: begin
				priority case (1'b1)
					cur.phase == PH_WRITE: begin
						if (base && !fl[FL_READ] && !fl[FL_ACK] && fl[FL_TXREQ]) begin
							// Send a byte, then flag last data once the count runs out
							if (cur.bytes_left == 8'd0) begin
								cmd0 = CMD_LAST;
							end else begin
								cmd0           = CMD_SEND;
								dat0           = item.data_byte;
								nxt.bytes_left = cur.bytes_left - 8'd1;
								if (cur.bytes_left == 8'd1) begin
									cmd1 = CMD_LAST;
									two  = 1'b1;
								end
							end
						end else if (fl[FL_STOP]) begin
							if (fl[FL_BUSERR] || cur.bytes_left != 8'd0 || cur.overrun) begin
								nxt.phase      = PH_ERROR;
								nxt.fault_code = 1'b1;
							end else begin
								nxt.phase = PH_WDONE;
								cmd0      = CMD_CLEAR;
							end
						end
					end
					cur.phase == PH_READ: begin
						if (base && fl[FL_READ] && !fl[FL_RXREQ] && !fl[FL_ACK]) begin
							cmd0 = CMD_ACK;
						end else if (base && fl[FL_READ] && fl[FL_RXREQ] &&
								!fl[FL_ADDRDATA]) begin
							// Hand out the received byte; NACK the final one
							cmd0 = (cur.bytes_left == 8'd1 && !cur.overrun) ?
								CMD_NACK_STOP : CMD_ACK;
							dat0 = item.data_byte;
							rxs0 = 1'b1;
							if (cur.bytes_left == 8'd0) begin
								nxt.overrun = 1'b1;
							end else begin
								nxt.bytes_left = cur.bytes_left - 8'd1;
							end
						end else if (fl[FL_STOP]) begin
							if (fl[FL_BUSERR] || cur.bytes_left != 8'd0 || cur.overrun) begin
								nxt.phase      = PH_ERROR;
								nxt.fault_code = 1'b1;
							end else begin
								nxt.phase = PH_RDONE;
								cmd0      = CMD_CLEAR;
							end
						end
					end
					cur.phase == PH_ERROR: begin
						nxt  = '{phase: PH_IDLE, default: '0};
						cmd0 = CMD_REINIT;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Pack both result transfers with the state after the step
	always_comb begin
		res.two             = two;
		res.r0.command      = cmd0;
		res.r0.data_out     = dat0;
		res.r0.rx_store     = rxs0;
		res.r0.driver_state = phase_code(nxt.phase);
		res.r0.error_code   = nxt.fault_code;
		res.r0.remaining    = nxt.bytes_left;
		res.r0.last         = !two;
		res.r1.command      = cmd1;
		res.r1.data_out     = dat1;
		res.r1.rx_store     = 1'b0;
		res.r1.driver_state = phase_code(nxt.phase);
		res.r1.error_code   = nxt.fault_code;
		res.r1.remaining    = nxt.bytes_left;
		res.r1.last         = 1'b1;
	end

endmodule

// ===== rtl/i2cts_out.sv =====
module i2cts_out
	import i2cts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  step_res_t res,
	output logic      can_load,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	out_item_t r0_q;
	out_item_t r1_q;
	logic      two_q;
	logic      sel_q;
	logic      valid_q;
	logic      fire;
	logic      done;

	assign fire     = valid_q && !result_stall;
	assign done     = fire && (sel_q || !two_q);
	assign can_load = !valid_q || done;

	assign result_valid = valid_q;
	assign result       = sel_q ? r1_q : r0_q;

	// Hold results, advance to the second transfer, drop when the last one is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
			two_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			sel_q   <= 1'b0;
			two_q   <= res.two;
		end else if (done) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (fire) begin
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= res.r0;
			r1_q <= res.r1;
		end
	end

endmodule

// ===== rtl/i2c_master_transfer_sequencer_unit.sv =====
// Channel  Direction  Payload     Handshake
// item     input      in_item_t   item_valid / item_stall
// result   output     out_item_t  result_valid / result_stall
//
// An item is registered on entry, processed combinationally and its results are
// registered in the result register, from which the first result is offered.
// An item yields one or two results; the result register sends one per cycle while
// result_stall is low, so the rate is one item per cycle for items with one result.
// Reset clears the transfer state to idle and empties both registers.
// A stalled result holds the input register, which then raises item_stall.
module i2c_master_transfer_sequencer_unit
	import i2cts_pkg::*;
#(
	parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	in_item_t   item_s1;
	logic       valid_s1;
	seq_state_t state_q;
	seq_state_t state_nxt;
	step_res_t  res;
	logic       can_load;
	logic       load;

	assign load       = valid_s1 && can_load;
	assign item_stall = valid_s1 && !can_load;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Transfer state, committed as the results are loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (load) begin
			state_q <= state_nxt;
		end
	end

	i2cts_step #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_step (
		.item(item_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res)
	);

	i2cts_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.res         (res),
		.can_load    (can_load),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// ===== test/i2c_master_transfer_sequencer_unit_tb.sv =====
module i2c_master_transfer_sequencer_unit_tb;
	import i2cts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ITEM_GOAL      = 1525;
	localparam int unsigned CALM_TAIL      = 200;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 12;

	// Opcodes outside the defined set
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	// Status flag masks
	localparam logic [9:0] MASK_BUSERR   = 10'(1) << FL_BUSERR;
	localparam logic [9:0] MASK_BUSY     = 10'(1) << FL_BUSY;
	localparam logic [9:0] MASK_STOP     = 10'(1) << FL_STOP;
	localparam logic [9:0] MASK_STRETCH  = 10'(1) << FL_STRETCH;
	localparam logic [9:0] MASK_READ     = 10'(1) << FL_READ;
	localparam logic [9:0] MASK_ACK      = 10'(1) << FL_ACK;
	localparam logic [9:0] MASK_TXREQ    = 10'(1) << FL_TXREQ;
	localparam logic [9:0] MASK_RXREQ    = 10'(1) << FL_RXREQ;
	localparam logic [9:0] MASK_LINEFREE = 10'(1) << FL_LINEFREE;
	localparam logic [9:0] MASK_ADDRDATA = 10'(1) << FL_ADDRDATA;

	// Flags that must be set or clear for each well-formed event
	localparam logic [9:0] SET_START = MASK_TXREQ | MASK_LINEFREE;
	localparam logic [9:0] CLR_START = MASK_BUSY;
	localparam logic [9:0] SET_TX    = MASK_BUSY | MASK_STRETCH | MASK_TXREQ;
	localparam logic [9:0] CLR_TX    = MASK_BUSERR | MASK_STOP | MASK_READ | MASK_ACK;
	localparam logic [9:0] SET_RDADR = MASK_BUSY | MASK_STRETCH | MASK_READ;
	localparam logic [9:0] CLR_RDADR = MASK_BUSERR | MASK_STOP | MASK_RXREQ | MASK_ACK;
	localparam logic [9:0] SET_RX    = MASK_BUSY | MASK_STRETCH | MASK_READ | MASK_RXREQ;
	localparam logic [9:0] CLR_RX    = MASK_BUSERR | MASK_STOP | MASK_ADDRDATA;

	logic      clk;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	in_item_t  pending_items[$];
	bit        hold_before[$];
	out_item_t expected_results[$];

	// Predicted sequencer state
	logic [2:0] seq_phase;
	logic [7:0] seq_left;
	logic [6:0] seq_addr;
	logic       seq_fault;
	logic       seq_overrun;

	int unsigned mismatches    = 0;
	int unsigned planned_items = 0;
	int unsigned send_gap      = 0;
	int unsigned stall_left    = 0;
	int unsigned quiet_cycles  = 0;
	logic [31:0] cycle_count   = '0;
	bit          hold_next     = 1'b0;

	i2c_master_transfer_sequencer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit idling_allowed();
		return pending_items.size() >= CALM_TAIL && cycle_count[8:7] != 2'b11;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [6:0] rand_addr();
		return 7'($urandom_range(0, 127));
	endfunction

	// Random flags with the given bits forced; noisy events sometimes stay fully random
	function automatic logic [9:0] event_flags(logic [9:0] set, logic [9:0] clr, bit noisy);
		logic [9:0] raw;
		raw = 10'($urandom_range(0, 1023));
		if (noisy && $urandom_range(0, 9) == 0)
			return raw;
		return (raw & ~clr) | set;
	endfunction

	task automatic clear_sequencer();
		seq_phase   = DS_IDLE;
		seq_left    = '0;
		seq_addr    = '0;
		seq_fault   = 1'b0;
		seq_overrun = 1'b0;
	endtask

	// Advance the predicted state by one transfer and queue its results
	task automatic predict_transfer(input in_item_t it);
		logic [3:0] cmd [2];
		logic [7:0] dat [2];
		logic       rxs [2];
		logic [9:0] fl;
		logic [7:0] len;
		bit         base;
		bit         at_stop;
		int         n;
		out_item_t  r;
		cmd[0] = CMD_NONE;
		cmd[1] = CMD_NONE;
		dat[0] = '0;
		dat[1] = '0;
		rxs[0] = 1'b0;
		rxs[1] = 1'b0;
		fl = it.status_flags;
		n = 1;
		at_stop = 1'b0;
		base = !fl[FL_BUSERR] && fl[FL_BUSY] && !fl[FL_STOP] && fl[FL_STRETCH];
		case (it.operation)
		OP_START_W, OP_START_R: begin
			len = (it.transfer_length > MAX_LENGTH_DEF) ? 8'(MAX_LENGTH_DEF)
				: it.transfer_length;
			seq_addr = it.slave_address;
			seq_left = len;
			seq_overrun = 1'b0;
			if (!fl[FL_BUSY] && fl[FL_TXREQ] && fl[FL_LINEFREE]) begin
				if (it.operation == OP_START_R) begin
					seq_phase = DS_READ;
					cmd[0] = CMD_START_R;
				end else begin
					seq_phase = DS_WRITE;
					cmd[0] = CMD_START_W;
				end
				dat[0] = {1'b0, seq_addr};
			end else begin
				seq_phase = DS_ERROR;
				seq_fault = 1'b1;
			end
		end
		OP_IDLE: seq_phase = DS_IDLE;
		OP_CLEAR: clear_sequencer();
		OP_STATUS: begin
			if (seq_phase == DS_WRITE) begin
				if (base && !fl[FL_READ] && !fl[FL_ACK] && fl[FL_TXREQ]) begin
					n = 0;
					if (seq_left != 0) begin
						cmd[0] = CMD_SEND;
						dat[0] = it.data_byte;
						n = 1;
						seq_left--;
					end
					if (seq_left == 0) begin
						cmd[n] = CMD_LAST;
						n++;
					end
				end else begin
					at_stop = fl[FL_STOP];
				end
			end else if (seq_phase == DS_READ) begin
				if (base && fl[FL_READ] && !fl[FL_RXREQ] && !fl[FL_ACK]) begin
					cmd[0] = CMD_ACK;
				end else if (base && fl[FL_READ] && fl[FL_RXREQ] && !fl[FL_ADDRDATA]) begin
					cmd[0] = (seq_left == 1 && !seq_overrun) ? CMD_NACK_STOP : CMD_ACK;
					dat[0] = it.data_byte;
					rxs[0] = 1'b1;
					if (seq_left == 0)
						seq_overrun = 1'b1;
					else
						seq_left--;
				end else begin
					at_stop = fl[FL_STOP];
				end
			end else if (seq_phase == DS_ERROR) begin
				clear_sequencer();
				cmd[0] = CMD_REINIT;
			end
			// Close the transfer at STOP
			if (at_stop) begin
				if (fl[FL_BUSERR] || seq_left != 0 || seq_overrun) begin
					seq_phase = DS_ERROR;
					seq_fault = 1'b1;
				end else begin
					seq_phase = (seq_phase == DS_WRITE) ? DS_WDONE : DS_RDONE;
					cmd[0] = CMD_CLEAR;
				end
			end
		end
		default: ;
		endcase
		for (int k = 0; k < n; k++) begin
			r.command      = cmd[k];
			r.data_out     = dat[k];
			r.rx_store     = rxs[k];
			r.driver_state = seq_phase;
			r.error_code   = seq_fault;
			r.remaining    = seq_left;
			r.last         = (k == n - 1);
			expected_results.push_back(r);
		end
	endtask

	function automatic int field_differs(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic add_transfer(logic [2:0] op, logic [6:0] addr, logic [7:0] len,
			logic [9:0] flags, logic [7:0] db);
		in_item_t it;
		it.operation       = op;
		it.slave_address   = addr;
		it.transfer_length = len;
		it.status_flags    = flags;
		it.data_byte       = db;
		pending_items.push_back(it);
		hold_before.push_back(hold_next);
		hold_next = 1'b0;
		if (op <= OP_CLEAR)
			planned_items++;
	endtask

	// One write or read transfer with random content; noisy ones may be malformed
	task automatic add_sequence(bit rd, logic [7:0] len, bit noisy);
		int events;
		add_transfer(rd ? OP_START_R : OP_START_W, rand_addr(), len,
			event_flags(SET_START, CLR_START, noisy), rand_byte());
		events = int'(len);
		if (noisy)
			events = events + int'($urandom_range(0, 2)) - 1;
		if (!rd) begin
			for (int k = 0; k <= events; k++)
				add_transfer(OP_STATUS, rand_addr(), rand_byte(),
					event_flags(SET_TX, CLR_TX, noisy), rand_byte());
		end else begin
			add_transfer(OP_STATUS, rand_addr(), rand_byte(),
				event_flags(SET_RDADR, CLR_RDADR, noisy), rand_byte());
			for (int k = 0; k < events; k++)
				add_transfer(OP_STATUS, rand_addr(), rand_byte(),
					event_flags(SET_RX, CLR_RX, noisy), rand_byte());
		end
		add_transfer(OP_STATUS, rand_addr(), rand_byte(),
			event_flags(MASK_STOP, ($urandom_range(0, 7) == 0) ? '0 : MASK_BUSERR, 1'b0),
			rand_byte());
	endtask

	// Driver: present queued items, with random gaps and one drain hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (pending_items.size() != 0
					&& !(hold_before[0] && (item_valid || expected_results.size() != 0))) begin
				item <= pending_items.pop_front();
				hold_before.delete(0);
				item_valid <= 1'b1;
				if (idling_allowed() && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 10);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor: check results, predict from accepted items, stall in bursts
	always @(posedge clk) begin
		out_item_t want;
		int bad;
		if (!arst_n) begin
			clear_sequencer();
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: expected no result, actual %h", $time, result);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					bad = field_differs("command", 8'(want.command), 8'(result.command))
						+ field_differs("data_out", want.data_out, result.data_out)
						+ field_differs("rx_store", 8'(want.rx_store), 8'(result.rx_store))
						+ field_differs("driver_state", 8'(want.driver_state),
							8'(result.driver_state))
						+ field_differs("error_code", 8'(want.error_code),
							8'(result.error_code))
						+ field_differs("remaining", want.remaining, result.remaining)
						+ field_differs("last", 8'(want.last), 8'(result.last));
					if (bad != 0)
						mismatches++;
				end
			end
			if (item_valid && !item_stall)
				predict_transfer(item);
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				result_stall <= 1'b1;
			end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 9);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int pick;
		bit pressure_done;
		pressure_done = 1'b0;

		// Directed: zero-length write, single-byte read, read past length
		add_transfer(OP_STATUS, 7'h00, 8'h00, SET_TX, 8'h00);
		add_transfer(OP_START_W, 7'h7f, 8'h00, SET_START, 8'hff);
		add_transfer(OP_STATUS, 7'h7f, 8'hff, SET_TX, 8'ha5);
		add_transfer(OP_STATUS, 7'h00, 8'h00, MASK_STOP, 8'h00);
		add_transfer(OP_STATUS, 7'h00, 8'h00, SET_TX, 8'h00);
		add_transfer(OP_START_R, 7'h00, 8'h01, SET_START, 8'h00);
		add_transfer(OP_STATUS, 7'h00, 8'h00, SET_RDADR, 8'h00);
		add_transfer(OP_STATUS, 7'h00, 8'h00, SET_RX, 8'hff);
		add_transfer(OP_STATUS, 7'h00, 8'h00, MASK_STOP, 8'h00);
		add_transfer(OP_START_R, 7'h2a, 8'h00, SET_START, 8'h00);
		add_transfer(OP_STATUS, 7'h00, 8'h00, SET_RX, 8'h3c);
		add_transfer(OP_STATUS, 7'h00, 8'h00, MASK_STOP, 8'h00);
		add_transfer(OP_STATUS, 7'h00, 8'h00, '0, 8'h00);
		// Refused start, then set idle and clear driver
		add_transfer(OP_START_W, 7'h55, 8'hff, SET_START | MASK_BUSY, 8'h00);
		add_transfer(OP_IDLE, 7'h7f, 8'hff, '1, 8'hff);
		add_transfer(OP_CLEAR, 7'h7f, 8'hff, '1, 8'hff);
		// Two-byte write ending on a bus error at STOP
		add_transfer(OP_START_W, 7'h01, 8'h02, '1 & ~MASK_BUSY, 8'h00);
		add_transfer(OP_STATUS, 7'h00, 8'h00, SET_TX, 8'h00);
		add_transfer(OP_STATUS, 7'h00, 8'h00, '1 & ~CLR_TX, 8'hff);
		add_transfer(OP_STATUS, 7'h00, 8'h00, MASK_STOP | MASK_BUSERR, 8'h00);
		// Undefined opcodes and starts with every flag or none
		add_transfer(OP_UNUSED_HI, 7'h7f, 8'hff, '1, 8'hff);
		add_transfer(OP_UNUSED_LO, 7'h00, 8'h00, '0, 8'h00);
		add_transfer(OP_START_W, 7'h7f, 8'hff, '1, 8'hff);
		add_transfer(OP_START_R, 7'h00, 8'h00, '0, 8'h00);
		add_transfer(OP_CLEAR, 7'h00, 8'h00, '0, 8'h00);

		// Random: mostly well-formed transfers, some noise
		while (planned_items < ITEM_GOAL) begin
			if (!pressure_done && planned_items > ITEM_GOAL / 2) begin
				hold_next = 1'b1;
				pressure_done = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				add_sequence(1'($urandom_range(0, 1)),
					($urandom_range(0, 29) == 0) ? rand_byte() : 8'($urandom_range(0, 5)),
					$urandom_range(0, 3) == 0);
			end else if (pick == 7) begin
				add_transfer(3'($urandom_range(0, 7)), rand_addr(), rand_byte(),
					10'($urandom_range(0, 1023)), rand_byte());
			end else if (pick == 8) begin
				add_transfer(OP_STATUS, rand_addr(), rand_byte(),
					10'($urandom_range(0, 1023)), rand_byte());
			end else begin
				add_transfer($urandom_range(0, 1) ? OP_IDLE : OP_CLEAR, rand_addr(),
					rand_byte(), 10'($urandom_range(0, 1023)), rand_byte());
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every transfer to be accepted and every result to come back
		do
			@(posedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
